@@ hw/rtl/sot_pkg.sv @@
// ----------------------------------------------------------------------------
// sot_pkg
// Shared types and constants for the session ownership table.
// ----------------------------------------------------------------------------
package sot_pkg;

    localparam int ENTRIES   = 16;
    localparam int TAG_BITS  = 32;
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int MAX_BITS  = 5;
    localparam int CMP_BITS  = (CNT_BITS > MAX_BITS) ? CNT_BITS : MAX_BITS;

    localparam int CMD_BITS  = 3;
    localparam int STAT_BITS = 3;

    // stream payload layout
    localparam int IN_RAW_BITS  = CMD_BITS + 3 * TAG_BITS;
    localparam int IN_BITS      = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = STAT_BITS + 2 + TAG_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-3:0] REG_IDX_MAX_SESSIONS = '0;
    localparam logic [MAX_BITS-1:0]      MAX_SESSIONS_RESET   = MAX_BITS'(16);

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLAIM       = 3'd0,
        CMD_TRANSFER    = 3'd1,
        CMD_HANDOFF     = 3'd2,
        CMD_RESUME      = 3'd3,
        CMD_QUERY_USER  = 3'd4,
        CMD_QUERY_OWNER = 3'd5,
        CMD_REL_OWNER   = 3'd6,
        CMD_REL_SESSION = 3'd7
    } cmd_t;

    typedef enum logic [STAT_BITS-1:0] {
        CLM_ACQUIRED = 3'd0,
        CLM_OWNED    = 3'd1,
        CLM_USER     = 3'd2,
        CLM_CONFLICT = 3'd3,
        CLM_FULL     = 3'd4,
        CLM_INVALID  = 3'd5
    } claim_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request
        logic scan;    // visit entry idx
        logic commit;  // decide, write back, fill output register
        idx_t idx;
    } dp_cmd_t;

endpackage

@@ hw/rtl/sot_ctrl.sv @@
// ----------------------------------------------------------------------------
// sot_ctrl
// Request sequencer: accept, scan all entries, commit into the output register.
// ----------------------------------------------------------------------------
module sot_ctrl
    import sot_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t dp_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;
    logic   out_valid_reg, out_valid_next;
    logic   load, commit;

    assign s_tready = (state_reg == ST_IDLE);
    assign load     = s_tvalid && s_tready;
    // commit waits while the previous response is still unclaimed
    assign commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    assign dp_cmd.load   = load;
    assign dp_cmd.scan   = (state_reg == ST_SCAN);
    assign dp_cmd.commit = commit;
    assign dp_cmd.idx    = idx_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (commit) begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN: begin
                if (idx_reg == IDX_BITS'(ENTRIES - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!out_valid_reg || m_tready))
        else $error("commit while output register still held");

    a_load_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (dp_cmd.scan && dp_cmd.idx == '0))
        else $error("scan did not start at entry zero");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_tvalid && s_tready))
        else $error("committed response not presented");

endmodule

@@ hw/rtl/sot_datapath.sv @@
// ----------------------------------------------------------------------------
// sot_datapath
// Entry storage, scan compare, decision logic and output register.
// ----------------------------------------------------------------------------
module sot_datapath
    import sot_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             dp_cmd,
    input  logic [IN_BITS-1:0]  s_tdata,
    input  logic [MAX_BITS-1:0] max_sessions,
    output logic [OUT_BITS-1:0] m_tdata
);

    // request
    cmd_t req_cmd_reg;
    tag_t req_sess_reg, req_own_reg, req_next_reg;

    // scan results
    logic hit_reg, hit_user_reg, free_seen_reg;
    idx_t hit_idx_reg, free_idx_reg;
    tag_t hit_owner_reg;

    // table
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] user_reg;
    tag_t               sess_reg  [ENTRIES];
    tag_t               owner_reg [ENTRIES];
    cnt_t               count_reg;

    // response
    claim_t stat_reg;
    logic   ok_reg, found_reg;
    tag_t   value_reg;

    logic   rd_valid, rd_user, sess_hit, rel_match;
    tag_t   rd_sess, rd_owner;
    logic   room, tags_ok, owner_eq;
    claim_t stat_next;
    logic   ok_next, found_next;
    tag_t   value_next;
    logic   alloc_en, alloc_user, set_user_en, set_user_val, set_owner_en;

    assign rd_valid = valid_reg[dp_cmd.idx];
    assign rd_user  = user_reg[dp_cmd.idx];
    assign rd_sess  = sess_reg[dp_cmd.idx];
    assign rd_owner = owner_reg[dp_cmd.idx];

    assign sess_hit = rd_valid && (req_sess_reg != '0) && (rd_sess == req_sess_reg);

    always_comb begin
        case (req_cmd_reg)
            CMD_REL_OWNER:
                rel_match = rd_valid && (req_own_reg != '0) && (rd_owner == req_own_reg);
            CMD_REL_SESSION:
                rel_match = sess_hit;
            default:
                rel_match = 1'b0;
        endcase
    end

    assign room = (CMP_BITS'(count_reg) < CMP_BITS'(max_sessions))
               && (count_reg < CNT_BITS'(ENTRIES));
    assign tags_ok  = (req_sess_reg != '0) && (req_own_reg != '0);
    assign owner_eq = (hit_owner_reg == req_own_reg);

    always_comb begin
        stat_next    = CLM_ACQUIRED;
        ok_next      = 1'b0;
        found_next   = 1'b0;
        value_next   = '0;
        alloc_en     = 1'b0;
        alloc_user   = 1'b0;
        set_user_en  = 1'b0;
        set_user_val = 1'b0;
        set_owner_en = 1'b0;
        case (req_cmd_reg)
            CMD_CLAIM: begin
                if (!tags_ok) begin
                    stat_next = CLM_INVALID;
                end else if (hit_reg) begin
                    if (!owner_eq) begin
                        stat_next = CLM_CONFLICT;
                    end else if (hit_user_reg) begin
                        stat_next = CLM_USER;
                    end else begin
                        stat_next = CLM_OWNED;
                    end
                end else if (!room) begin
                    stat_next = CLM_FULL;
                end else begin
                    alloc_en = 1'b1;
                end
            end
            CMD_TRANSFER: begin
                if ((req_own_reg != '0) && (req_next_reg != '0) && hit_reg
                        && !hit_user_reg && owner_eq) begin
                    set_owner_en = 1'b1;
                    ok_next      = 1'b1;
                end
            end
            CMD_HANDOFF: begin
                if (tags_ok) begin
                    if (hit_reg) begin
                        if (owner_eq) begin
                            set_user_en  = 1'b1;
                            set_user_val = 1'b1;
                            ok_next      = 1'b1;
                        end
                    end else if (room) begin
                        alloc_en   = 1'b1;
                        alloc_user = 1'b1;
                        ok_next    = 1'b1;
                    end
                end
            end
            CMD_RESUME: begin
                if (tags_ok && hit_reg && owner_eq) begin
                    set_user_en = 1'b1;
                    ok_next     = 1'b1;
                end
            end
            CMD_QUERY_USER: begin
                ok_next = tags_ok && hit_reg && hit_user_reg && owner_eq;
            end
            CMD_QUERY_OWNER: begin
                if (hit_reg && !hit_user_reg) begin
                    found_next = 1'b1;
                    value_next = hit_owner_reg;
                end
            end
            default: begin
                // releases act during the scan
            end
        endcase
    end

    // request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            req_cmd_reg   <= cmd_t'(s_tdata[CMD_BITS-1:0]);
            req_sess_reg  <= s_tdata[CMD_BITS +: TAG_BITS];
            req_own_reg   <= s_tdata[CMD_BITS + TAG_BITS +: TAG_BITS];
            req_next_reg  <= s_tdata[CMD_BITS + 2 * TAG_BITS +: TAG_BITS];
            hit_reg       <= 1'b0;
            free_seen_reg <= 1'b0;
        end else if (dp_cmd.scan) begin
            if (sess_hit) begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= dp_cmd.idx;
                hit_user_reg  <= rd_user;
                hit_owner_reg <= rd_owner;
            end
            // lowest free slot wins
            if (!rd_valid && !free_seen_reg) begin
                free_seen_reg <= 1'b1;
                free_idx_reg  <= dp_cmd.idx;
            end
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (dp_cmd.scan && rel_match) begin
            valid_reg[dp_cmd.idx] <= 1'b0;
            if (count_reg != '0) begin
                count_reg <= count_reg - 1'b1;
            end
        end else if (dp_cmd.commit && alloc_en) begin
            valid_reg[free_idx_reg] <= 1'b1;
            count_reg <= count_reg + 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            if (alloc_en) begin
                user_reg[free_idx_reg]  <= alloc_user;
                sess_reg[free_idx_reg]  <= req_sess_reg;
                owner_reg[free_idx_reg] <= req_own_reg;
            end
            if (set_user_en) begin
                user_reg[hit_idx_reg] <= set_user_val;
            end
            if (set_owner_en) begin
                owner_reg[hit_idx_reg] <= req_next_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            stat_reg  <= stat_next;
            ok_reg    <= ok_next;
            found_reg <= found_next;
            value_reg <= value_next;
        end
    end

    assign m_tdata = OUT_BITS'({value_reg, found_reg, ok_reg, stat_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(ENTRIES))
        else $error("occupied count above table size");

    a_alloc_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.commit && alloc_en) |-> (free_seen_reg && !hit_reg))
        else $error("allocation without a free slot or over an existing session");

endmodule

@@ hw/rtl/session_ownership_table_unit.sv @@
// ----------------------------------------------------------------------------
// session_ownership_table_unit
// Session write-ownership table: claim, transfer, handoff, resume, queries
// and releases over a fixed set of entries, one request at a time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata: command, session, owner, next owner
//  m_*       out  tvalid/tready      tdata: claim_status, success, found, owner
//  apb       in   psel/penable       max_sessions at byte address 0
//
//  A request passes through accept, a sequential scan of every table entry
//  and a commit for decision and write-back.
//  The commit waits while the previous response has not been taken; a new
//  request is accepted while a response sits in the output register.
//  Synchronous active-low reset empties the table and sets max_sessions to 16.
// ----------------------------------------------------------------------------
module session_ownership_table_unit
    import sot_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command[2:0], session_tag[34:3], owner_tag[66:35], next_owner_tag[98:67]
    input  logic [IN_BITS-1:0]       s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // claim_status[2:0], success[3], owner_found[4], owner_value[36:5]
    output logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    dp_cmd_t             dp_cmd;
    logic [MAX_BITS-1:0] max_sessions_reg;
    logic                sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[APB_ADDR_BITS-1:2] == REG_IDX_MAX_SESSIONS);
    assign prdata  = sel_max ? APB_DATA_BITS'(max_sessions_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_sessions_reg <= MAX_SESSIONS_RESET;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            max_sessions_reg <= pwdata[MAX_BITS-1:0];
        end
    end

    sot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    sot_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dp_cmd       (dp_cmd),
        .s_tdata      (s_tdata),
        .max_sessions (max_sessions_reg),
        .m_tdata      (m_tdata)
    );

endmodule

@@ tb/sv/sot_checker.sv @@
// ----------------------------------------------------------------------------
// sot_checker
// Watches the request, response and register ports of the session ownership
// table, keeps its own copy of the table, and compares every response with
// the answer that the copy gives for the matching request.
// ----------------------------------------------------------------------------
module sot_checker
    import sot_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // command[2:0], session_tag[34:3], owner_tag[66:35], next_owner_tag[98:67]
    input  logic [IN_BITS-1:0]       s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // claim_status[2:0], success[3], owner_found[4], owner_value[36:5]
    input  logic [OUT_BITS-1:0]      m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output int                       errors,
    output int                       pending,
    output int                       responses
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        claim_t status;
        logic   success;
        logic   found;
        tag_t   owner;
    } answer_t;

    logic               tbl_valid [ENTRIES];
    logic               tbl_user  [ENTRIES];
    tag_t               tbl_sess  [ENTRIES];
    tag_t               tbl_owner [ENTRIES];
    int                 occupied;
    logic [MAX_BITS-1:0] capacity;

    answer_t answer_q [$];
    int      mismatches;
    int      checked;

    function automatic int lookup(tag_t s);
        if (s == '0)
            return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_sess[i] == s)
                return i;
        return -1;
    endfunction

    function automatic bit has_room();
        return occupied < int'(capacity) && occupied < ENTRIES;
    endfunction

    // first free slot takes the new entry
    function automatic void occupy(tag_t s, tag_t o, logic user);
        for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_user[i]  = user;
                tbl_sess[i]  = s;
                tbl_owner[i] = o;
                occupied++;
                return;
            end
        end
    endfunction

    function automatic void drop(bit by_owner, tag_t t);
        if (t == '0)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && (by_owner ? tbl_owner[i] : tbl_sess[i]) == t) begin
                tbl_valid[i] = 1'b0;
                if (occupied > 0)
                    occupied--;
            end
        end
    endfunction

    function automatic answer_t table_apply(cmd_t c, tag_t s, tag_t o, tag_t n);
        answer_t a;
        int      e;
        // fields a command does not produce stay zero
        a.status  = CLM_ACQUIRED;
        a.success = 1'b0;
        a.found   = 1'b0;
        a.owner   = '0;
        e = lookup(s);
        case (c)
            CMD_CLAIM: begin
                if (s == '0 || o == '0)
                    a.status = CLM_INVALID;
                else if (e >= 0 && tbl_user[e])
                    a.status = (tbl_owner[e] == o) ? CLM_USER : CLM_CONFLICT;
                else if (e >= 0)
                    a.status = (tbl_owner[e] == o) ? CLM_OWNED : CLM_CONFLICT;
                else if (!has_room())
                    a.status = CLM_FULL;
                else
                    occupy(s, o, 1'b0);
            end
            CMD_TRANSFER: begin
                if (o != '0 && n != '0 && e >= 0 && !tbl_user[e] && tbl_owner[e] == o) begin
                    tbl_owner[e] = n;
                    a.success    = 1'b1;
                end
            end
            CMD_HANDOFF: begin
                if (s != '0 && o != '0) begin
                    if (e >= 0) begin
                        if (tbl_owner[e] == o) begin
                            tbl_user[e] = 1'b1;
                            a.success   = 1'b1;
                        end
                    end else if (has_room()) begin
                        occupy(s, o, 1'b1);
                        a.success = 1'b1;
                    end
                end
            end
            CMD_RESUME: begin
                if (s != '0 && o != '0 && e >= 0 && tbl_owner[e] == o) begin
                    tbl_user[e] = 1'b0;
                    a.success   = 1'b1;
                end
            end
            CMD_QUERY_USER: begin
                if (s != '0 && o != '0 && e >= 0 && tbl_user[e] && tbl_owner[e] == o)
                    a.success = 1'b1;
            end
            CMD_QUERY_OWNER: begin
                if (e >= 0 && !tbl_user[e]) begin
                    a.found = 1'b1;
                    a.owner = tbl_owner[e];
                end
            end
            CMD_REL_OWNER:   drop(1'b1, o);
            default:         drop(1'b0, s);
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_user[i]  = 1'b0;
                tbl_sess[i]  = '0;
                tbl_owner[i] = '0;
            end
            occupied   = 0;
            capacity   = MAX_SESSIONS_RESET;
            mismatches = 0;
            checked    = 0;
            answer_q.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_BITS-1:2] == REG_IDX_MAX_SESSIONS)
                capacity = pwdata[MAX_BITS-1:0];

            // a response always belongs to an older request, so check first
            if (m_tvalid && m_tready) begin
                got.status  = claim_t'(m_tdata[STAT_BITS-1:0]);
                got.success = m_tdata[STAT_BITS];
                got.found   = m_tdata[STAT_BITS+1];
                got.owner   = m_tdata[STAT_BITS+2 +: TAG_BITS];
                if (answer_q.size() == 0) begin
                    if (mismatches < 10)
                        $display({"%0t: response with no request pending: ",
                                  "status %0d ok %0b found %0b owner %h"},
                                 $realtime, got.status, got.success, got.found,
                                 got.owner);
                    mismatches++;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%0t: response %0d: ",
                                      "exp status %0d ok %0b found %0b owner %h, ",
                                      "got status %0d ok %0b found %0b owner %h"},
                                     $realtime, checked, want.status, want.success,
                                     want.found, want.owner, got.status, got.success,
                                     got.found, got.owner);
                        mismatches++;
                    end
                end
                checked++;
            end

            if (s_tvalid && s_tready)
                answer_q = {answer_q,
                            table_apply(cmd_t'(s_tdata[CMD_BITS-1:0]),
                                        s_tdata[CMD_BITS +: TAG_BITS],
                                        s_tdata[CMD_BITS+TAG_BITS +: TAG_BITS],
                                        s_tdata[CMD_BITS+2*TAG_BITS +: TAG_BITS])};
        end
        pending   <= answer_q.size();
        errors    <= mismatches;
        responses <= checked;
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the session ownership table with a directed request sequence and
// then random command mixes over small tag pools, under several capacity
// settings, with random gaps and stalls on both streams and one long
// response back-pressure stretch. The checker instance grades the responses.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sot_pkg::*;

    localparam int MAX_CYCLES  = 400000;
    localparam int DRAIN       = ENTRIES + 2 + 22;
    localparam int HOLD_CYCLES = 500;
    localparam int PHASE_ITEMS = 172;
    localparam int SESS_POOL   = 20;
    localparam int OWNER_POOL  = 4;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    // command[2:0], session_tag[34:3], owner_tag[66:35], next_owner_tag[98:67]
    logic [IN_BITS-1:0]       s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // claim_status[2:0], success[3], owner_found[4], owner_value[36:5]
    logic [OUT_BITS-1:0]      m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int errors;
    int pending;
    int responses;
    int cycles = 0;
    int sent = 0;
    int settings = 0;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hold = 1'b0;

    tag_t sess_pool  [SESS_POOL];
    tag_t owner_pool [OWNER_POOL];

    session_ownership_table_unit dut (.*);

    sot_checker watch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending),
        .responses (responses)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("[session_ownership_table_unit] ERROR");
            $finish;
        end
    end

    // response side: random stall per response, one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic wait_idle();
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic set_capacity(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({REG_IDX_MAX_SESSIONS, 2'b00});
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    task automatic send_request(input cmd_t c, input tag_t s, input tag_t o, input tag_t n);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'({n, o, s, c});
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sent++;
    endtask

    // mostly pooled tags so entries collide; the rest is raw noise
    task automatic run_random_phase(input int count);
        int   r;
        int   w;
        cmd_t c;
        tag_t s;
        tag_t o;
        tag_t n;
        for (int i = 0; i < SESS_POOL; i++)
            do sess_pool[i] = $urandom; while (sess_pool[i] == '0);
        for (int i = 0; i < OWNER_POOL; i++)
            do owner_pool[i] = $urandom; while (owner_pool[i] == '0);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                w = $urandom_range(0, 99);
                if (w < 30)      c = CMD_CLAIM;
                else if (w < 40) c = CMD_TRANSFER;
                else if (w < 55) c = CMD_HANDOFF;
                else if (w < 65) c = CMD_RESUME;
                else if (w < 75) c = CMD_QUERY_USER;
                else if (w < 85) c = CMD_QUERY_OWNER;
                else if (w < 88) c = CMD_REL_OWNER;
                else             c = CMD_REL_SESSION;
                s = sess_pool[$urandom_range(0, SESS_POOL - 1)];
                o = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
                n = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
            end else begin
                c = cmd_t'($urandom_range(0, 7));
                s = ($urandom_range(0, 3) == 0) ? tag_t'(0) : tag_t'($urandom);
                o = ($urandom_range(0, 3) == 0) ? tag_t'(0) : tag_t'($urandom);
                n = ($urandom_range(0, 3) == 0) ? tag_t'(0) : tag_t'($urandom);
            end
            send_request(c, s, o, n);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int   caps [8];
        tag_t sa;
        tag_t sb;
        tag_t sc;
        tag_t ox;
        tag_t oy;
        caps = '{16, 0, 1, 16, 5, -1, 16, 12};
        sa = 32'h0000_0001;
        sb = 32'hFFFF_FFFF;
        sc = 32'h8000_0000;
        ox = 32'h0000_0005;
        oy = 32'hFFFF_FFFF;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: capacity 2 so the full case is reachable
        set_capacity(2);
        send_request(CMD_CLAIM,       '0, ox, '0);   // zero session
        send_request(CMD_CLAIM,       sa, '0, '0);   // zero owner
        send_request(CMD_CLAIM,       sa, ox, '0);   // acquired
        send_request(CMD_CLAIM,       sa, ox, '0);   // already owned
        send_request(CMD_CLAIM,       sa, oy, '0);   // conflict
        send_request(CMD_QUERY_OWNER, sa, '0, '0);
        send_request(CMD_TRANSFER,    sa, ox, '0);   // zero next owner
        send_request(CMD_TRANSFER,    sa, oy, ox);   // wrong owner
        send_request(CMD_TRANSFER,    sa, ox, oy);
        send_request(CMD_HANDOFF,     sa, oy, '0);   // mode switch in place
        send_request(CMD_QUERY_USER,  sa, oy, '0);
        send_request(CMD_QUERY_OWNER, sa, '0, '0);   // user entry: not found
        send_request(CMD_CLAIM,       sa, oy, '0);   // user control
        send_request(CMD_CLAIM,       sa, ox, '0);   // conflict on user entry
        send_request(CMD_HANDOFF,     sb, ox, '0);   // new user entry
        send_request(CMD_CLAIM,       sc, ox, '0);   // full
        send_request(CMD_HANDOFF,     sc, ox, '0);   // full
        send_request(CMD_RESUME,      sa, ox, '0);   // wrong owner
        send_request(CMD_RESUME,      sa, oy, '0);
        send_request(CMD_QUERY_USER,  sa, oy, '0);
        send_request(CMD_HANDOFF,     '0, ox, '0);
        send_request(CMD_RESUME,      sb, '0, '0);
        send_request(CMD_REL_SESSION, '0, ox, '0);   // zero tag releases nothing
        send_request(CMD_REL_OWNER,   sa, '0, '0);
        send_request(CMD_REL_OWNER,   sa, ox, '0);
        send_request(CMD_REL_SESSION, sa, '0, '0);
        send_request(CMD_QUERY_OWNER, sa, '0, '0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_capacity(caps[p] < 0 ? $urandom_range(0, 16) : caps[p]);
            tx_calm = (p == 3 || p == 6);
            rx_calm = (p == 6);
            rx_hold = (p == 3);
            run_random_phase(PHASE_ITEMS);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        wait_idle();
        repeat (DRAIN) @(posedge aclk);
        $display("run: %0d requests under %0d capacity settings from 0 to 16, %0d responses checked",
                 sent, settings, responses);
        $display("run: random stalls both ways, one %0d-cycle response hold-off", HOLD_CYCLES);
        if (errors == 0)
            $display("[session_ownership_table_unit] OK");
        else
            $display("[session_ownership_table_unit] ERROR");
        $finish;
    end

endmodule
